// ===== rtl/checksum_frame_deframer_macros.svh =====
// assertion helpers for the deframer rtl
`ifndef CHECKSUM_FRAME_DEFRAMER_MACROS_SVH
`define CHECKSUM_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every rising clock edge outside reset
`define CFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cfd assertion failed");

// consequent holds in the cycle after the antecedent
`define CFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfd assertion failed");

`else

`define CFD_ASSERT(lbl, clk, rst_n, prop)
`define CFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/cfd_pkg.sv =====
package cfd_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  // bytes kept between requests; the last frame byte is the incoming one
  localparam int unsigned WIN_BYTES   = FRAME_BYTES - 1;
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES);

  typedef logic [7:0] byte_t;
  typedef byte_t [WIN_BYTES-1:0] win_t;

  localparam byte_t HDR_FIRST_RST  = 8'hAA;
  localparam byte_t HDR_SECOND_RST = 8'h55;
  localparam byte_t SIZE_BYTE_VAL  = byte_t'(FRAME_BYTES);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_BYTES);

  // register index as decoded from paddr[2]
  localparam logic REG_HDR_FIRST  = 1'b0;
  localparam logic REG_HDR_SECOND = 1'b1;

  typedef struct packed {
    logic hdr_ok;
    logic len_ok;
    logic sum_ok;
  } chk_t;

endpackage

// ===== rtl/checksum_frame_deframer.sv =====
// an accepted byte waits in the input register; its frame result loads into the result register when it advances
// throughput: one byte per cycle; input register, window check and result register
// run concurrently, the only hold-off being a stalled full result register
// reset: rst_ni asynchronous active low; clears the window, byte count, valid flags
// and sets the header registers to 0xAA and 0x55
`include "checksum_frame_deframer_macros.svh"

module checksum_frame_deframer
  import cfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  command_code_o,
  output logic [7:0]  device_type_o,
  output logic [7:0]  device_index_o,
  output logic [15:0] payload_value_o
);

  byte_t hdr_first_q, hdr_second_q;

  logic  s1_valid_q, s1_valid_d;
  byte_t s1_byte_q;

  win_t             win_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic  out_valid_q, out_valid_d;
  byte_t cmd_q, dtype_q, didx_q;
  logic [15:0] value_q;

  chk_t chk;
  logic in_acc, adv, full, pass;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HDR_FIRST_RST;
      hdr_second_q <= HDR_SECOND_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HDR_FIRST:  hdr_first_q  <= pwdata[7:0];
        REG_HDR_SECOND: hdr_second_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HDR_FIRST:  prdata = {24'd0, hdr_first_q};
      REG_HDR_SECOND: prdata = {24'd0, hdr_second_q};
      default:        prdata = '0;
    endcase
  end

  // input register; a held byte moves on once the result slot is free or being taken
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  cfd_frame_check u_check (
    .win_i        (win_q),
    .last_byte_i  (s1_byte_q),
    .hdr_first_i  (hdr_first_q),
    .hdr_second_i (hdr_second_q),
    .chk_o        (chk)
  );

  assign full = (cnt_q == CNT_FULL);
  assign pass = full && chk.hdr_ok && chk.len_ok && chk.sum_ok;

  // a rejected full window keeps its count: the shift drops the oldest byte
  always_comb begin
    cnt_d = cnt_q;
    if (adv) begin
      if (pass) begin
        cnt_d = '0;
      end else if (!full) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // window shifts towards index 0; newest byte enters at the top
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (adv) begin
        win_q <= {s1_byte_q, win_q[WIN_BYTES-1:1]};
      end
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && pass) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && pass) begin
      cmd_q   <= win_q[3];
      dtype_q <= win_q[4];
      didx_q  <= win_q[5];
      value_q <= {win_q[6], win_q[7]};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_code_o  = cmd_q;
  assign device_type_o   = dtype_q;
  assign device_index_o  = didx_q;
  assign payload_value_o = value_q;

  `CFD_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_FULL)
  `CFD_ASSERT_NEXT(a_pass_clears, clk_i, rst_ni, adv && pass, cnt_q == '0 && out_valid_q)
  `CFD_ASSERT_NEXT(a_reject_keeps, clk_i, rst_ni, adv && full && !pass, cnt_q == CNT_FULL)
  `CFD_ASSERT(a_stall_held, clk_i, rst_ni, !in_stall_o || (s1_valid_q && out_valid_q))
  `CFD_ASSERT(a_rose_src, clk_i, rst_ni, !$rose(out_valid_q) || $past(adv && pass))

endmodule

// ===== rtl/cfd_frame_check.sv =====
module cfd_frame_check
  import cfd_pkg::*;
(
  input  win_t  win_i,
  input  byte_t last_byte_i,
  input  byte_t hdr_first_i,
  input  byte_t hdr_second_i,
  output chk_t  chk_o
);

  byte_t sum;

  // win_i[0] is the oldest held byte, i.e. frame byte 0
  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_BYTES; i++) begin
      sum = sum + win_i[i];
    end
  end

  assign chk_o.hdr_ok = (win_i[0] == hdr_first_i) && (win_i[1] == hdr_second_i);
  assign chk_o.len_ok = (win_i[2] == SIZE_BYTE_VAL);
  assign chk_o.sum_ok = (sum == last_byte_i);

endmodule

// ===== bench/checksum_frame_deframer_tb.sv =====
module checksum_frame_deframer_tb;
  import cfd_pkg::*;

  typedef struct packed {
    byte_t       cmd;
    byte_t       dev_type;
    byte_t       dev_index;
    logic [15:0] value;
  } frame_fields_t;

  typedef struct packed {
    byte_t         rx;
    logic          typed;
    frame_fields_t fields;
  } directed_row_t;

  typedef enum int {
    BREAK_HDR_FIRST,
    BREAK_HDR_SECOND,
    BREAK_LEN,
    BREAK_SUM,
    BREAK_SHORT
  } frame_break_e;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_BYTES   = 160;
  localparam int unsigned N_PHASES      = 6;
  localparam int unsigned DIRECTED_LEN  = 27;
  localparam frame_fields_t NO_FRAME    = '0;

  // reset headers: all-ones payload, a bad checksum, then a zero frame that has to
  // be found again one byte at a time
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{8'hAA, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME}, '{8'h09, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
    '{8'h03, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 16'hFFFF}},
    '{8'hAA, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME}, '{8'h09, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h07, 1'b0, NO_FRAME},
    '{8'hAA, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME}, '{8'h09, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
    '{8'h08, 1'b1, '{8'h00, 8'h00, 8'h00, 16'h0000}}
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  command_code_o;
  logic [7:0]  device_type_o;
  logic [7:0]  device_index_o;
  logic [15:0] payload_value_o;

  checksum_frame_deframer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_code_o (command_code_o),
    .device_type_o  (device_type_o),
    .device_index_o (device_index_o),
    .payload_value_o(payload_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // deframer state as the testbench sees it
  byte_t         hdr_first_q  = HDR_FIRST_RST;
  byte_t         hdr_second_q = HDR_SECOND_RST;
  byte_t         rx_window [FRAME_BYTES];
  int unsigned   rx_held      = 0;
  frame_fields_t pending_frames [$];

  int unsigned errors    = 0;
  int unsigned cycle_cnt = 0;
  bit          src_calm  = 1'b0;
  bit          snk_calm  = 1'b0;

  function automatic bit deframe_byte(input byte_t rx, output frame_fields_t fields);
    int    i;
    byte_t sum;
    fields = NO_FRAME;
    rx_window[rx_held] = rx;
    rx_held++;
    if (rx_held < FRAME_BYTES) return 1'b0;
    sum = '0;
    for (i = 0; i < FRAME_BYTES - 1; i++) sum = sum + rx_window[i];
    if (rx_window[0] == hdr_first_q && rx_window[1] == hdr_second_q &&
        rx_window[2] == SIZE_BYTE_VAL && sum == rx_window[FRAME_BYTES-1]) begin
      fields = '{rx_window[3], rx_window[4], rx_window[5], {rx_window[6], rx_window[7]}};
      rx_held = 0;
      return 1'b1;
    end
    // drop the oldest byte and try again on the next one
    for (i = 0; i < FRAME_BYTES - 1; i++) rx_window[i] = rx_window[i+1];
    rx_window[FRAME_BYTES-1] = '0;
    rx_held = FRAME_BYTES - 1;
    return 1'b0;
  endfunction

  task automatic send_byte(input byte_t rx, input logic typed, input frame_fields_t typed_fields);
    int unsigned   gap;
    bit            hit;
    frame_fields_t got;
    gap = src_calm ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (in_stall_o);
    hit = deframe_byte(rx, got);
    if (typed) pending_frames.push_back(typed_fields);
    else if (hit) pending_frames.push_back(got);
  endtask

  task automatic wait_drained(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_HDR_FIRST) hdr_first_q = value[7:0];
    else hdr_second_q = value[7:0];
  endtask

  // mostly well-formed frames under the current headers, some broken ones and noise
  task automatic run_traffic(input int unsigned n_bytes);
    byte_t       frame [FRAME_BYTES];
    byte_t       sum;
    byte_t       flip;
    int unsigned len;
    int unsigned sent;
    int unsigned roll;
    int unsigned i;
    sent = 0;
    while (sent < n_bytes) begin
      roll = $urandom_range(0, 9);
      if (roll >= 8) begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) send_byte(byte_t'($urandom_range(0, 255)), 1'b0, NO_FRAME);
      end else begin
        frame[0] = hdr_first_q;
        frame[1] = hdr_second_q;
        frame[2] = SIZE_BYTE_VAL;
        for (i = 3; i < FRAME_BYTES - 1; i++) frame[i] = byte_t'($urandom_range(0, 255));
        sum = '0;
        for (i = 0; i < FRAME_BYTES - 1; i++) sum = sum + frame[i];
        frame[FRAME_BYTES-1] = sum;
        len = FRAME_BYTES;
        if (roll == 7) begin
          flip = byte_t'($urandom_range(1, 255));
          case (frame_break_e'($urandom_range(BREAK_HDR_FIRST, BREAK_SHORT)))
            BREAK_HDR_FIRST:  frame[0] = frame[0] ^ flip;
            BREAK_HDR_SECOND: frame[1] = frame[1] ^ flip;
            BREAK_LEN:        frame[2] = frame[2] ^ flip;
            BREAK_SUM:        frame[FRAME_BYTES-1] = frame[FRAME_BYTES-1] ^ flip;
            default:          len = $urandom_range(1, FRAME_BYTES - 1);
          endcase
        end
        for (i = 0; i < len; i++) send_byte(frame[i], 1'b0, NO_FRAME);
      end
      sent += len;
    end
  endtask

  initial begin : result_sink
    frame_fields_t want;
    int unsigned   hold;
    @(posedge rst_ni);
    forever begin
      hold = snk_calm ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 29) == 0) snk_calm = !snk_calm;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_frames.size() == 0) begin
        $error("frame result with none pending: command_code %0h", command_code_o);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (command_code_o !== want.cmd) begin
          $error("command_code: expected %0h, got %0h", want.cmd, command_code_o);
          errors++;
        end
        if (device_type_o !== want.dev_type) begin
          $error("device_type: expected %0h, got %0h", want.dev_type, device_type_o);
          errors++;
        end
        if (device_index_o !== want.dev_index) begin
          $error("device_index: expected %0h, got %0h", want.dev_index, device_index_o);
          errors++;
        end
        if (payload_value_o !== want.value) begin
          $error("payload_value: expected %0h, got %0h", want.value, payload_value_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL checksum_frame_deframer");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned row;
    int unsigned phase;
    byte_t       hf;
    byte_t       hs;
    foreach (rx_window[row]) rx_window[row] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < DIRECTED_LEN; row++)
      send_byte(DIRECTED_ROWS[row].rx, DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].fields);
    run_traffic(PHASE_BYTES);

    for (phase = 1; phase < N_PHASES; phase++) begin
      case (phase)
        1:       begin hf = 8'h00; hs = 8'h00; end
        2:       begin hf = 8'hFF; hs = 8'hFF; end
        3:       begin hf = SIZE_BYTE_VAL; hs = 8'hFF; end
        default: begin
          hf = byte_t'($urandom_range(0, 255));
          hs = byte_t'($urandom_range(0, 255));
        end
      endcase
      wait_drained(SETTLE_CYCLES);
      // upper bits are junk on purpose, only the low byte is kept
      write_reg(REG_HDR_FIRST, {24'($urandom()), hf});
      write_reg(REG_HDR_SECOND, {24'($urandom()), hs});
      run_traffic(PHASE_BYTES);
    end

    wait_drained(2 * SETTLE_CYCLES);
    if (errors == 0) $display("PASS checksum_frame_deframer");
    else $display("FAIL checksum_frame_deframer");
    $finish;
  end

endmodule
